>>> hdl/dnsc_pkg.sv
package dnsc_pkg;

	localparam logic [7:0]  TAG_SEQ     = 8'h30;
	localparam logic [7:0]  LEN_2B      = 8'h82;
	localparam logic [15:0] MIN_LEN     = 16'h0100;
	localparam logic [15:0] HDR_ROOM    = 16'd4;
	localparam logic [15:0] MAX_LEN_RST = 16'd4096;
	localparam int          HDR_BYTES   = 8;

	// command passed from the parser to the emitter
	typedef struct packed {
		logic        is_hdr;
		logic [7:0]  data;
		logic [15:0] outer_len;
		logic [15:0] inner_len;
		logic [15:0] rec_num;
		logic        rec_end;
	} cmd_t;

	// byte of the rebuilt eight-byte header at position idx
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx,
		input logic [15:0] outer_len, input logic [15:0] inner_len);
		logic [7:0] b;
		case (idx)
			3'd0: b = TAG_SEQ;
			3'd1: b = LEN_2B;
			3'd2: b = outer_len[15:8];
			3'd3: b = outer_len[7:0];
			3'd4: b = TAG_SEQ;
			3'd5: b = LEN_2B;
			3'd6: b = inner_len[15:8];
			default: b = inner_len[7:0];
		endcase
		return b;
	endfunction

endpackage

>>> hdl/dnsc_ifs.sv
interface dnsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface dnsc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [15:0] record_number;
	logic        record_start;
	logic        record_end;
	logic        run_last;

	modport source (output valid, output out_byte, output record_number,
		output record_start, output record_end, output run_last, input ready);
	modport sink (input valid, input out_byte, input record_number,
		input record_start, input record_end, input run_last, output ready);
endinterface

>>> hdl/dnsc_fifo.sv
module dnsc_fifo
	import dnsc_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && push && !pop) |=> full)
		else $error("queue lost its fill on a rejected push");
`endif

endmodule

>>> hdl/dnsc_front.sv
module dnsc_front
	import dnsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	dnsc_in_if.sink     in_ch,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	localparam logic [3:0] PH_OTAG = 4'd0;
	localparam logic [3:0] PH_OLEN = 4'd1;
	localparam logic [3:0] PH_OHI  = 4'd2;
	localparam logic [3:0] PH_OLO  = 4'd3;
	localparam logic [3:0] PH_ITAG = 4'd4;
	localparam logic [3:0] PH_ILEN = 4'd5;
	localparam logic [3:0] PH_IHI  = 4'd6;
	localparam logic [3:0] PH_ILO  = 4'd7;
	localparam logic [3:0] PH_BODY = 4'd8;

	logic [3:0]  phase_q,      phase_d;
	logic [15:0] outer_len_q,  outer_len_d;
	logic [7:0]  inner_hi_q,   inner_hi_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] rec_cnt_q,    rec_cnt_d;
	logic [15:0] max_len_q;
	logic        fire;
	logic [7:0]  b;
	logic [15:0] outer_now;
	logic [15:0] inner_now;
	logic        body_end;

	assign in_ch.ready = !q_full;
	assign fire        = in_ch.valid && !q_full;
	assign b           = in_ch.data_byte;
	assign outer_now   = {outer_len_q[15:8], b};
	assign inner_now   = {inner_hi_q, b};
	assign body_end    = (bytes_left_q <= 16'd1);

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// header scan and payload tagging
	always_comb begin
		phase_d      = phase_q;
		outer_len_d  = outer_len_q;
		inner_hi_d   = inner_hi_q;
		bytes_left_d = bytes_left_q;
		rec_cnt_d    = rec_cnt_q;
		push         = 1'b0;
		push_cmd     = '0;
		push_cmd.rec_num = rec_cnt_q;
		if (fire) begin
			unique case (phase_q)
				PH_OTAG: phase_d = (b == TAG_SEQ) ? PH_OLEN : PH_OTAG;
				PH_OLEN: phase_d = (b == LEN_2B) ? PH_OHI : PH_OTAG;
				PH_OHI: begin
					outer_len_d = {b, 8'h00};
					phase_d     = PH_OLO;
				end
				PH_OLO: begin
					outer_len_d = outer_now;
					phase_d     = (outer_now >= MIN_LEN && outer_now <= max_len_q)
						? PH_ITAG : PH_OTAG;
				end
				PH_ITAG: phase_d = (b == TAG_SEQ) ? PH_ILEN : PH_OTAG;
				PH_ILEN: phase_d = (b == LEN_2B) ? PH_IHI : PH_OTAG;
				PH_IHI: begin
					inner_hi_d = b;
					phase_d    = PH_ILO;
				end
				PH_ILO: begin
					if (inner_now >= MIN_LEN && inner_now <= max_len_q
						&& inner_now < outer_len_q) begin
						push               = 1'b1;
						push_cmd.is_hdr    = 1'b1;
						push_cmd.outer_len = outer_len_q;
						push_cmd.inner_len = inner_now;
						bytes_left_d       = outer_len_q - HDR_ROOM;
						phase_d            = PH_BODY;
					end else begin
						phase_d = PH_OTAG;
					end
				end
				PH_BODY: begin
					push             = 1'b1;
					push_cmd.data    = b;
					push_cmd.rec_end = body_end;
					if (body_end) begin
						bytes_left_d = '0;
						rec_cnt_d    = rec_cnt_q + 16'd1;
						phase_d      = PH_OTAG;
					end else begin
						bytes_left_d = bytes_left_q - 16'd1;
					end
				end
				default: phase_d = PH_OTAG;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OTAG;
			outer_len_q  <= '0;
			inner_hi_q   <= '0;
			bytes_left_q <= '0;
			rec_cnt_q    <= '0;
		end else begin
			phase_q      <= phase_d;
			outer_len_q  <= outer_len_d;
			inner_hi_q   <= inner_hi_d;
			bytes_left_q <= bytes_left_d;
			rec_cnt_q    <= rec_cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_rec_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_cnt_q != $past(rec_cnt_q)) |-> ($past(phase_q) == PH_BODY))
		else $error("record count moved outside a payload transaction");
`endif

endmodule

>>> hdl/dnsc_back.sv
module dnsc_back
	import dnsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head_cmd,
	input  logic       q_empty,
	output logic       pop,
	dnsc_out_if.source out_ch
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] rec_num_q;
	logic        rec_start_q;
	logic        rec_end_q;
	logic        run_last_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	cmd_t        hdr_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = out_free && !busy_q && !q_empty;

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.record_number = rec_num_q;
	assign out_ch.record_start  = rec_start_q;
	assign out_ch.record_end    = rec_end_q;
	assign out_ch.run_last      = run_last_q;

	// header expansion control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else if (out_free) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 3'd1;
				busy_q      <= (idx_q != 3'(HDR_BYTES - 1));
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				busy_q      <= head_cmd.is_hdr;
				idx_q       <= 3'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (busy_q) begin
				out_byte_q  <= hdr_byte(idx_q, hdr_q.outer_len, hdr_q.inner_len);
				rec_num_q   <= hdr_q.rec_num;
				rec_start_q <= 1'b0;
				rec_end_q   <= 1'b0;
				run_last_q  <= (idx_q == 3'(HDR_BYTES - 1));
			end else if (pop) begin
				hdr_q     <= head_cmd;
				rec_num_q <= head_cmd.rec_num;
				if (head_cmd.is_hdr) begin
					out_byte_q  <= TAG_SEQ;
					rec_start_q <= 1'b1;
					rec_end_q   <= 1'b0;
					run_last_q  <= 1'b0;
				end else begin
					out_byte_q  <= head_cmd.data;
					rec_start_q <= 1'b0;
					rec_end_q   <= head_cmd.rec_end;
					run_last_q  <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> hdr_q.is_hdr)
		else $error("header expansion running on a payload command");
	a_busy_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> out_valid_q)
		else $error("header expansion with no transaction on the output");
	a_start_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_start_q) |-> (busy_q && idx_q == 3'd1))
		else $error("record start outside the first header byte");
`endif

endmodule

>>> hdl/der_nested_sequence_carver_core.sv
// nested der sequence carver: scans a byte stream for an outer sequence
// header 30 82 hh ll followed at once by an inner header 30 82 hh ll, and
// carves the record that it opens
// in_ch: one raw byte per transaction; one byte is taken every cycle while
// the command queue has room
// out_ch: carved bytes tagged with record number, record start and end and
// a run_last mark on the last result of each input byte
// cfg_we/cfg_wdata: writes max_len, the largest accepted length (inclusive)
// a header byte gives no result; the last inner length byte gives the eight
// header bytes; each payload byte gives one result (outer length minus four
// of them)
// each result is registered in the command queue and then in the emitter
// output register before it is valid on out_ch
// throughput: one input byte per cycle while the queue has room; the emitter
// sustains one result per cycle while out_ch is ready, and the queue of
// FIFO_DEPTH commands absorbs the header burst; reset: the scan restarts at
// the outer tag, the record count is zero, the queue is empty and max_len is 4096
// a stalled output holds its transaction; the queue then fills and in_ch
// ready drops until the receiver takes results again
module der_nested_sequence_carver_core
	import dnsc_pkg::*;
#(
	parameter int FIFO_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	dnsc_in_if.sink     in_ch,
	dnsc_out_if.source  out_ch
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head_cmd;
	logic q_empty;
	logic q_full;

	// header parser
	dnsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// command queue
	dnsc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	// result emitter
	dnsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

>>> sim/tb_der_nested_sequence_carver_core.sv
module tb_der_nested_sequence_carver_core;
	import dnsc_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PCT     = 21;
	localparam int MAX_REPORTS  = 100;
	localparam int GAP_BYTES    = 120;

	// scan phases of the carver
	typedef enum logic [3:0] {
		SCAN_OTAG,
		SCAN_OLEN,
		SCAN_OHI,
		SCAN_OLO,
		SCAN_ITAG,
		SCAN_ILEN,
		SCAN_IHI,
		SCAN_ILO,
		SCAN_BODY
	} scan_phase_e;

	// one carved output byte with its marks
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] record_number;
		logic        record_start;
		logic        record_end;
		logic        run_last;
	} carved_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	dnsc_in_if  in_ch ();
	dnsc_out_if out_ch ();

	der_nested_sequence_carver_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// carver state as predicted
	scan_phase_e prd_phase   = SCAN_OTAG;
	logic [15:0] prd_outer   = '0;
	logic [15:0] prd_inner   = '0;
	logic [15:0] prd_left    = '0;
	logic [15:0] prd_count   = '0;
	logic [15:0] prd_max_len = MAX_LEN_RST;

	carved_t carved_q[$];
	carved_t carved_got;
	carved_t carved_exp;

	int mismatch_count = 0;
	int sent_count     = 0;
	int cycle_count    = 0;
	bit idle_on        = 1'b1;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d results outstanding", $time,
				carved_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
	end

	function automatic bit len_valid(input logic [15:0] len);
		return (len >= MIN_LEN) && (len <= prd_max_len);
	endfunction

	function automatic void queue_carved(input logic [7:0] b, input logic start,
		input logic rec_end, input logic last);
		carved_t c;
		c.out_byte      = b;
		c.record_number = prd_count;
		c.record_start  = start;
		c.record_end    = rec_end;
		c.run_last      = last;
		carved_q.push_back(c);
	endfunction

	// advance the predicted carver by one accepted byte
	function automatic void carve_predict(input logic [7:0] b);
		bit last;
		case (prd_phase)
			SCAN_OTAG: prd_phase = (b == TAG_SEQ) ? SCAN_OLEN : SCAN_OTAG;
			SCAN_OLEN: prd_phase = (b == LEN_2B) ? SCAN_OHI : SCAN_OTAG;
			SCAN_OHI: begin
				prd_outer = {b, 8'h00};
				prd_phase = SCAN_OLO;
			end
			SCAN_OLO: begin
				prd_outer = {prd_outer[15:8], b};
				prd_phase = len_valid(prd_outer) ? SCAN_ITAG : SCAN_OTAG;
			end
			SCAN_ITAG: prd_phase = (b == TAG_SEQ) ? SCAN_ILEN : SCAN_OTAG;
			SCAN_ILEN: prd_phase = (b == LEN_2B) ? SCAN_IHI : SCAN_OTAG;
			SCAN_IHI: begin
				prd_inner = {b, 8'h00};
				prd_phase = SCAN_ILO;
			end
			SCAN_ILO: begin
				prd_inner = {prd_inner[15:8], b};
				if (!len_valid(prd_inner) || (prd_inner >= prd_outer)) begin
					prd_phase = SCAN_OTAG;
				end else begin
					// rebuilt header burst
					queue_carved(TAG_SEQ, 1'b1, 1'b0, 1'b0);
					queue_carved(LEN_2B, 1'b0, 1'b0, 1'b0);
					queue_carved(prd_outer[15:8], 1'b0, 1'b0, 1'b0);
					queue_carved(prd_outer[7:0], 1'b0, 1'b0, 1'b0);
					queue_carved(TAG_SEQ, 1'b0, 1'b0, 1'b0);
					queue_carved(LEN_2B, 1'b0, 1'b0, 1'b0);
					queue_carved(prd_inner[15:8], 1'b0, 1'b0, 1'b0);
					queue_carved(prd_inner[7:0], 1'b0, 1'b0, 1'b1);
					prd_left  = prd_outer - HDR_ROOM;
					prd_phase = SCAN_BODY;
				end
			end
			SCAN_BODY: begin
				last = (prd_left <= 16'd1);
				queue_carved(b, 1'b0, last, 1'b1);
				if (last) begin
					prd_left  = '0;
					prd_count = prd_count + 16'd1;
					prd_phase = SCAN_OTAG;
				end else begin
					prd_left = prd_left - 16'd1;
				end
			end
			default: prd_phase = SCAN_OTAG;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			carved_got = {out_ch.out_byte, out_ch.record_number, out_ch.record_start,
				out_ch.record_end, out_ch.run_last};
			if (carved_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display({"%0t: unexpected result: expected none, ",
						"got byte %h rec %0d start %b end %b last %b"},
						$time, carved_got.out_byte, carved_got.record_number,
						carved_got.record_start, carved_got.record_end, carved_got.run_last);
			end else begin
				carved_exp = carved_q.pop_front();
				if (carved_got !== carved_exp) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: mismatch: expected byte %h rec %0d start %b end %b ",
							"last %b, got byte %h rec %0d start %b end %b last %b"},
							$time, carved_exp.out_byte, carved_exp.record_number,
							carved_exp.record_start, carved_exp.record_end, carved_exp.run_last,
							carved_got.out_byte, carved_got.record_number,
							carved_got.record_start, carved_got.record_end, carved_got.run_last);
				end
			end
		end
	end

	// one input transaction, with random gaps in front
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		carve_predict(b);
		sent_count++;
	endtask

	// tag, long form length and a 16-bit length
	task automatic send_len_header(input logic [15:0] len);
		send_byte(TAG_SEQ);
		send_byte(LEN_2B);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// random payload until the predicted record is closed
	task automatic send_payload();
		while (prd_phase == SCAN_BODY) send_byte(8'($urandom_range(0, 255)));
	endtask

	// stop sending and wait until every expected result is in
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (carved_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		prd_max_len = value;
	endtask

	// default max_len: one above is dropped, equal is taken as outer length
	task automatic test_reset_max_len();
		send_len_header(MAX_LEN_RST + 16'd1);
		send_len_header(MAX_LEN_RST);
		send_len_header(MAX_LEN_RST);
	endtask

	// shortest record the default setting allows, the tail with no idling
	task automatic test_min_record();
		send_len_header(16'h0101);
		send_len_header(16'h0100);
		for (int i = 0; i < GAP_BYTES && prd_phase == SCAN_BODY; i++) begin
			send_byte(8'($urandom_range(0, 255)));
		end
		idle_on = 1'b0;
		send_payload();
		drain_results();
		idle_on = 1'b1;
	endtask

	// broken tags and long form marks restart the scan
	task automatic test_broken_patterns();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(LEN_2B);
		send_byte(TAG_SEQ);
		send_byte(8'h00);
		send_byte(TAG_SEQ);
		send_byte(TAG_SEQ);
		send_byte(LEN_2B);
		send_len_header(16'h0101);
		send_byte(8'h31);
		send_len_header(16'h0101);
		send_byte(TAG_SEQ);
		send_byte(8'h81);
	endtask

	// lengths out of range and inner not below outer
	task automatic test_bad_lengths();
		send_len_header(16'h00FF);
		send_len_header(16'hFFFF);
		send_len_header(16'h0110);
		send_len_header(16'h0110);
		send_len_header(16'h0110);
		send_len_header(16'h00FF);
		send_len_header(16'h0110);
		send_len_header(16'h0000);
	endtask

	// max_len below 257 never carves
	task automatic test_small_max_len();
		write_max_len(16'h0000);
		send_len_header(16'h0101);
		send_len_header(16'h0100);
		write_max_len(16'h0100);
		send_len_header(16'h0100);
		send_len_header(16'h00FF);
		send_len_header(16'h0100);
		send_len_header(16'h0100);
	endtask

	// outer length equal to max_len is accepted
	task automatic test_max_len_inclusive();
		write_max_len(16'd300);
		send_len_header(16'd301);
		send_len_header(16'd300);
		send_len_header(16'd300);
	endtask

	// new max_len applies to the length that is still being read
	task automatic test_mid_scan_write();
		write_max_len(MAX_LEN_RST);
		send_byte(TAG_SEQ);
		send_byte(LEN_2B);
		send_byte(8'h01);
		write_max_len(16'h0100);
		send_byte(8'h2C);
		send_len_header(16'h0100);
		send_len_header(16'h00FF);
	endtask

	// random noise rich in tags and long form marks
	task automatic test_random_noise();
		int n;
		write_max_len(16'd300);
		n = $urandom_range(16, 24);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: send_byte(TAG_SEQ);
				1: send_byte(LEN_2B);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
		send_payload();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_max_len();
		test_min_record();
		test_broken_patterns();
		test_bad_lengths();
		test_small_max_len();
		test_max_len_inclusive();
		test_mid_scan_write();
		test_random_noise();

		drain_results();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
